@@ hdl/ray_triangle_intersect_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ray/triangle intersection block
// Shared property forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define RTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle check failed.");

`endif

@@ hdl/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection package
// Widths, register codes and transaction types shared by the block.
// ----------------------------------------------------------------------------
package rti_pkg;

   localparam int COORD_BITS      = 20;
   localparam int COORD_FRAC_BITS = 8;
   localparam int T_FRAC_BITS     = 16;

   localparam int VEC_BITS   = 60;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
   localparam int LO_BITS    = CROSS_BITS / 2;
   localparam int HI_BITS    = CROSS_BITS - LO_BITS;
   localparam int NUM_BITS   = DIFF_BITS + CROSS_BITS + 2;
   localparam int Q_BITS     = 32;
   localparam int REM_BITS   = NUM_BITS + Q_BITS;
   localparam int CSR_BITS   = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DET_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_T_MINIMUM     = 2'd1;

   localparam logic [CSR_BITS-1:0] DET_THRESHOLD_RESET = 32'd17;
   localparam logic [CSR_BITS-1:0] T_MINIMUM_RESET     = 32'd1;

   typedef struct packed {
      logic [VEC_BITS-1:0] vertex_two;
      logic [VEC_BITS-1:0] vertex_one;
      logic [VEC_BITS-1:0] vertex_zero;
      logic [VEC_BITS-1:0] ray_direction;
      logic [VEC_BITS-1:0] ray_origin;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic [Q_BITS-1:0]   distance;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic                cand;
      logic                sat;
      logic [NUM_BITS-1:0] num;
      logic [NUM_BITS-1:0] den;
   } div_in_type;

   typedef struct packed {
      logic              valid;
      logic              cand;
      logic              sat;
      logic [Q_BITS-1:0] quotient;
   } div_out_type;

endpackage

@@ hdl/rti_divider.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per register stage for the ray distance.
// ----------------------------------------------------------------------------
module rti_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rti_pkg::div_in_type  div_in,
   output rti_pkg::div_out_type div_out
);
   import rti_pkg::*;

   logic                valid_ff [Q_BITS+1];
   logic                cand_ff  [Q_BITS+1];
   logic                sat_ff   [Q_BITS+1];
   logic [REM_BITS-1:0] rem_ff   [Q_BITS+1];
   logic [NUM_BITS-1:0] den_ff   [Q_BITS+1];
   logic [Q_BITS-1:0]   q_ff     [Q_BITS+1];
   logic                ge_in    [Q_BITS];
   logic [REM_BITS-1:0] rem_in   [Q_BITS];

   always_comb begin
      for (int j = 0; j < Q_BITS; j++) begin
         ge_in[j]  = rem_ff[j] >= (REM_BITS'(den_ff[j]) << (Q_BITS - 1 - j));
         rem_in[j] = ge_in[j] ? rem_ff[j] - (REM_BITS'(den_ff[j]) << (Q_BITS - 1 - j))
                              : rem_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      valid_ff[0] <= reset ? 1'b0 : div_in.valid;
      cand_ff[0]  <= div_in.cand;
      sat_ff[0]   <= div_in.sat;
      rem_ff[0]   <= REM_BITS'(div_in.num) << T_FRAC_BITS;
      den_ff[0]   <= div_in.den;
      q_ff[0]     <= '0;
      for (int j = 0; j < Q_BITS; j++) begin
         valid_ff[j+1] <= reset ? 1'b0 : valid_ff[j];
         cand_ff[j+1]  <= cand_ff[j];
         sat_ff[j+1]   <= sat_ff[j];
         rem_ff[j+1]   <= rem_in[j];
         den_ff[j+1]   <= den_ff[j];
         q_ff[j+1]     <= {q_ff[j][Q_BITS-2:0], ge_in[j]};
      end
   end

   assign div_out.valid    = valid_ff[Q_BITS];
   assign div_out.cand     = cand_ff[Q_BITS];
   assign div_out.sat      = sat_ff[Q_BITS];
   assign div_out.quotient = q_ff[Q_BITS];

endmodule

@@ hdl/ray_triangle_intersect.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection
// Fixed-point intersection test of one ray against one triangle per cycle.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low.
// Busy is always low, so one ray/triangle pair may enter every cycle.
// Each request carries the ray origin, ray direction and three vertices.
// The result appears with rsp_strobe high for one cycle; it carries the hit
// flag and the distance in Q16.16.
// Seven arithmetic stages form the edges, cross products, dot products and
// acceptance tests, 32 divider stages produce one quotient bit each, and a
// final stage applies the minimum distance.
// The receiver cannot hold results off, so the pipeline never stalls.
// Reset clears all valid bits and restores the determinant threshold to 17
// and the minimum distance to 1. The user must write the registers through
// the csr port while no transaction is in flight; the block does not check it.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_macros.svh"

module ray_triangle_intersect (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  rti_pkg::req_type                       req,
   output logic                                   rsp_strobe,
   output rti_pkg::rsp_type                       rsp,
   input  logic                                   csr_write_enable,
   input  logic [rti_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [rti_pkg::CSR_BITS-1:0]           csr_write_data
);
   import rti_pkg::*;

   function automatic logic signed [NUM_BITS-1:0] dot_sum(
      input logic signed [DIFF_BITS+LO_BITS:0]   lo0,
      input logic signed [DIFF_BITS+LO_BITS:0]   lo1,
      input logic signed [DIFF_BITS+LO_BITS:0]   lo2,
      input logic signed [DIFF_BITS+HI_BITS-1:0] hi0,
      input logic signed [DIFF_BITS+HI_BITS-1:0] hi1,
      input logic signed [DIFF_BITS+HI_BITS-1:0] hi2);
      logic signed [NUM_BITS-1:0] acc;
      acc = (NUM_BITS'(hi0) <<< LO_BITS) + NUM_BITS'(lo0)
          + (NUM_BITS'(hi1) <<< LO_BITS) + NUM_BITS'(lo1)
          + (NUM_BITS'(hi2) <<< LO_BITS) + NUM_BITS'(lo2);
      return acc;
   endfunction

   logic [CSR_BITS-1:0] det_thr_ff;
   logic [CSR_BITS-1:0] t_min_ff;

   logic                        v_ff [1:6];
   logic signed [DIFF_BITS-1:0] d1_ff [3], e11_ff [3], e21_ff [3], s1_ff [3];
   logic signed [DIFF_BITS-1:0] d2_ff [3], e12_ff [3], e22_ff [3], s2_ff [3];
   logic signed [DIFF_BITS-1:0] d3_ff [3], e13_ff [3], e23_ff [3], s3_ff [3];
   logic signed [2*DIFF_BITS-1:0] pa_ff [3], pb_ff [3], qa_ff [3], qb_ff [3];
   logic signed [CROSS_BITS-1:0]  p_ff [3], q_ff [3];
   logic signed [DIFF_BITS+LO_BITS:0]   lo_ff [4][3];
   logic signed [DIFF_BITS+HI_BITS-1:0] hi_ff [4][3];
   logic signed [NUM_BITS-1:0] det5_ff, un5_ff, vn5_ff, tn5_ff;
   logic [NUM_BITS-1:0]        det6_ff, un6_ff, vn6_ff, tn6_ff;
   div_in_type  div_in_ff;
   div_out_type div_out;
   logic [Q_BITS-1:0] t_val;
   logic              rsp_strobe_ff;
   rsp_type           rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_thr_ff <= DET_THRESHOLD_RESET;
         t_min_ff   <= T_MINIMUM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DET_THRESHOLD: det_thr_ff <= csr_write_data;
            CSR_T_MINIMUM:     t_min_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      v_ff[1] <= reset ? 1'b0 : start && !busy;
      for (int i = 2; i < 7; i++) begin
         v_ff[i] <= reset ? 1'b0 : v_ff[i-1];
      end
      for (int k = 0; k < 3; k++) begin
         d1_ff[k]  <= DIFF_BITS'($signed(req.ray_direction[k*COORD_BITS +: COORD_BITS]));
         e11_ff[k] <= DIFF_BITS'($signed(req.vertex_one[k*COORD_BITS +: COORD_BITS]))
                    - DIFF_BITS'($signed(req.vertex_zero[k*COORD_BITS +: COORD_BITS]));
         e21_ff[k] <= DIFF_BITS'($signed(req.vertex_two[k*COORD_BITS +: COORD_BITS]))
                    - DIFF_BITS'($signed(req.vertex_zero[k*COORD_BITS +: COORD_BITS]));
         s1_ff[k]  <= DIFF_BITS'($signed(req.ray_origin[k*COORD_BITS +: COORD_BITS]))
                    - DIFF_BITS'($signed(req.vertex_zero[k*COORD_BITS +: COORD_BITS]));
         pa_ff[k] <= d1_ff[(k+1)%3] * e21_ff[(k+2)%3];
         pb_ff[k] <= d1_ff[(k+2)%3] * e21_ff[(k+1)%3];
         qa_ff[k] <= s1_ff[(k+1)%3] * e11_ff[(k+2)%3];
         qb_ff[k] <= s1_ff[(k+2)%3] * e11_ff[(k+1)%3];
         d2_ff[k] <= d1_ff[k];
         e12_ff[k] <= e11_ff[k];
         e22_ff[k] <= e21_ff[k];
         s2_ff[k] <= s1_ff[k];
         p_ff[k] <= CROSS_BITS'(pa_ff[k]) - CROSS_BITS'(pb_ff[k]);
         q_ff[k] <= CROSS_BITS'(qa_ff[k]) - CROSS_BITS'(qb_ff[k]);
         d3_ff[k] <= d2_ff[k];
         e13_ff[k] <= e12_ff[k];
         e23_ff[k] <= e22_ff[k];
         s3_ff[k] <= s2_ff[k];
         lo_ff[0][k] <= e13_ff[k] * $signed({1'b0, p_ff[k][LO_BITS-1:0]});
         hi_ff[0][k] <= e13_ff[k] * $signed(p_ff[k][CROSS_BITS-1:LO_BITS]);
         lo_ff[1][k] <= s3_ff[k] * $signed({1'b0, p_ff[k][LO_BITS-1:0]});
         hi_ff[1][k] <= s3_ff[k] * $signed(p_ff[k][CROSS_BITS-1:LO_BITS]);
         lo_ff[2][k] <= d3_ff[k] * $signed({1'b0, q_ff[k][LO_BITS-1:0]});
         hi_ff[2][k] <= d3_ff[k] * $signed(q_ff[k][CROSS_BITS-1:LO_BITS]);
         lo_ff[3][k] <= e23_ff[k] * $signed({1'b0, q_ff[k][LO_BITS-1:0]});
         hi_ff[3][k] <= e23_ff[k] * $signed(q_ff[k][CROSS_BITS-1:LO_BITS]);
      end
      det5_ff <= dot_sum(lo_ff[0][0], lo_ff[0][1], lo_ff[0][2],
                         hi_ff[0][0], hi_ff[0][1], hi_ff[0][2]);
      un5_ff  <= dot_sum(lo_ff[1][0], lo_ff[1][1], lo_ff[1][2],
                         hi_ff[1][0], hi_ff[1][1], hi_ff[1][2]);
      vn5_ff  <= dot_sum(lo_ff[2][0], lo_ff[2][1], lo_ff[2][2],
                         hi_ff[2][0], hi_ff[2][1], hi_ff[2][2]);
      tn5_ff  <= dot_sum(lo_ff[3][0], lo_ff[3][1], lo_ff[3][2],
                         hi_ff[3][0], hi_ff[3][1], hi_ff[3][2]);
      det6_ff <= det5_ff[NUM_BITS-1] ? NUM_BITS'(-det5_ff) : NUM_BITS'(det5_ff);
      un6_ff  <= det5_ff[NUM_BITS-1] ? NUM_BITS'(-un5_ff)  : NUM_BITS'(un5_ff);
      vn6_ff  <= det5_ff[NUM_BITS-1] ? NUM_BITS'(-vn5_ff)  : NUM_BITS'(vn5_ff);
      tn6_ff  <= det5_ff[NUM_BITS-1] ? NUM_BITS'(-tn5_ff)  : NUM_BITS'(tn5_ff);
      div_in_ff.valid <= reset ? 1'b0 : v_ff[6];
      div_in_ff.cand  <= (det6_ff != '0)
                      && (det6_ff >= NUM_BITS'(det_thr_ff))
                      && !un6_ff[NUM_BITS-1] && (un6_ff <= det6_ff)
                      && !vn6_ff[NUM_BITS-1]
                      && ((NUM_BITS+1)'(un6_ff) + (NUM_BITS+1)'(vn6_ff)
                          <= (NUM_BITS+1)'(det6_ff))
                      && !tn6_ff[NUM_BITS-1];
      div_in_ff.sat   <= (REM_BITS'(tn6_ff) >= (REM_BITS'(det6_ff) << (Q_BITS - T_FRAC_BITS)));
      div_in_ff.num   <= tn6_ff;
      div_in_ff.den   <= det6_ff;
   end

   rti_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in_ff),
      .div_out (div_out)
   );

   assign t_val = div_out.sat ? '1 : div_out.quotient;

   always_ff @(posedge clock) begin
      rsp_strobe_ff   <= reset ? 1'b0 : div_out.valid;
      rsp_ff.hit      <= div_out.cand && (t_val >= t_min_ff);
      rsp_ff.distance <= (div_out.cand && (t_val >= t_min_ff)) ? t_val : '0;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   `RTI_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy, v_ff[1])
   `RTI_ASSERT_NEXT(a_divider_to_output, clock, reset, div_out.valid, rsp_strobe)
   `RTI_ASSERT_SAME(a_hit_distance, clock, reset, rsp_strobe && rsp.hit, rsp.distance >= t_min_ff)
   `RTI_ASSERT_SAME(a_miss_zero, clock, reset, rsp_strobe && !rsp.hit, rsp.distance == '0)

endmodule
